// ===== rtl/maze_dfs_backtracker_defines.svh =====
// Assertion macros shared by the maze generator RTL.
// Expects signals named clk and rst in the including module.
`ifndef MAZE_DFS_BACKTRACKER_DEFINES_SVH
`define MAZE_DFS_BACKTRACKER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define MDFS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check a condition in the cycle after its trigger
`define MDFS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/mdfs_pkg.sv =====
// Shared types and constants of the maze generator.
// No dependencies.
package mdfs_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int STACK_DEPTH = 1024;
  localparam int COORD_W     = 6;
  localparam int TILE_AW     = 2 * COORD_W;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = STACK_AW + 1;
  localparam int SIZE_W      = 7;
  localparam int RAND_W      = 15;
  localparam int CELLS_W     = 11;

  // opcodes
  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_RESTARTED = 3'd0;
  localparam logic [2:0] ST_CARVED    = 3'd1;
  localparam logic [2:0] ST_END_REJ   = 3'd2;
  localparam logic [2:0] ST_END_OK    = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_FINISHED  = 3'd5;

  // tile kinds
  localparam logic [1:0] TK_WALL  = 2'd0;
  localparam logic [1:0] TK_EMPTY = 2'd1;
  localparam logic [1:0] TK_END   = 2'd2;

  // configuration register indexes
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [RAND_W-1:0]  rand_a;
    logic [RAND_W-1:0]  rand_b;
    logic [COORD_W-1:0] read_row;
    logic [COORD_W-1:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] wall_row;
    logic [COORD_W-1:0] wall_col;
    logic [1:0]         tile_kind;
    logic               maze_done;
  } out_word_t;

  // request to and answer from the shared remainder unit
  typedef struct packed {
    logic               start;
    logic [RAND_W-1:0]  dividend;
    logic [COORD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] rem;
  } mod_resp_t;

endpackage

// ===== rtl/mdfs_mod.sv =====
// Shared bit-serial remainder unit: one dividend bit per cycle.
// Depends on mdfs_pkg.
module mdfs_mod import mdfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mod_req_t  req,
  output mod_resp_t resp
);

  logic               busy;
  logic               done;
  logic [3:0]         step;
  logic [RAND_W-1:0]  quo;
  logic [COORD_W-1:0] rem;
  logic [COORD_W-1:0] div;
  logic [COORD_W:0]   trial;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[RAND_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: restoring remainder step
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      div <= req.divisor;
    end else if (busy) begin
      quo <= quo << 1;
      if (trial >= {1'b0, div}) begin
        rem <= COORD_W'(trial - {1'b0, div});
      end else begin
        rem <= trial[COORD_W-1:0];
      end
    end
  end

  assign resp.done = done;
  assign resp.rem  = rem;

endmodule

// ===== rtl/maze_dfs_backtracker.sv =====
// Maze generator top level: sequencer, tile memory and path stack.
// Depends on mdfs_pkg, mdfs_mod and maze_dfs_backtracker_defines.svh.
//
// Randomized depth-first maze generator on a 64 x 64 tile memory. One word is
// taken at a time; in_ready is high only while the sequencer is idle. After
// reset and after every restart word the tile memory is swept to walls, one
// tile a cycle, before the block takes a word again (the restart result
// follows the sweep). A carve step inspects stack entries in turn: it fetches
// the top, probes each neighbor through the single tile read port and counts
// the open ones, then picks and carves with the bit-serial remainder unit.
// An end attempt makes two passes through the same remainder unit and one
// tile read. Results wait in an output register, so a word can be taken
// while the previous result is still unclaimed.
`include "maze_dfs_backtracker_defines.svh"

module maze_dfs_backtracker import mdfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  typedef enum logic [19:0] {
    S_CLEAR = 20'b00000000000000000001,
    S_SEED  = 20'b00000000000000000010,
    S_IDLE  = 20'b00000000000000000100,
    S_RD    = 20'b00000000000000001000,
    S_RDW   = 20'b00000000000000010000,
    S_TOP   = 20'b00000000000000100000,
    S_TOPW  = 20'b00000000000001000000,
    S_NBRD  = 20'b00000000000010000000,
    S_NBCK  = 20'b00000000000100000000,
    S_PICK  = 20'b00000000001000000000,
    S_MODC  = 20'b00000000010000000000,
    S_WR1   = 20'b00000000100000000000,
    S_WR2   = 20'b00000001000000000000,
    S_ENDC  = 20'b00000010000000000000,
    S_ENDCW = 20'b00000100000000000000,
    S_ENDR  = 20'b00001000000000000000,
    S_ENDRW = 20'b00010000000000000000,
    S_ENDRD = 20'b00100000000000000000,
    S_ENDCK = 20'b01000000000000000000,
    S_OUT   = 20'b10000000000000000000
  } state_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_CARVE = 4'b0010,
    PH_END   = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  state_t state, state_next;
  phase_t phase;

  logic [SIZE_W-1:0]  grid_cols, grid_rows;
  logic [SIZE_W-1:0]  cur_cols, cur_rows;
  logic [CELLS_W-1:0] cells;
  logic [CELLS_W-1:0] vtotal;
  logic [DEPTH_W-1:0] depth;
  logic               seed_pend;
  logic [TILE_AW-1:0] clr_addr;
  in_word_t           in_q;
  out_word_t          res;
  out_word_t          out_next;

  logic [COORD_W-1:0] cr, cc, tr, tc, wr, wc, er, ec;
  logic [1:0]         nb_i;
  logic [3:0]         mask;

  // memories
  logic [1:0]          tile_mem [2**TILE_AW];
  logic [1:0]          tile_rdata;
  logic                tile_we;
  logic [TILE_AW-1:0]  tile_waddr, tile_raddr;
  logic [1:0]          tile_wdata;
  logic [TILE_AW-1:0]  stack_mem [STACK_DEPTH];
  logic [TILE_AW-1:0]  stack_rdata;
  logic                stack_we;
  logic [STACK_AW-1:0] stack_waddr, stack_raddr;

  mod_req_t  mod_req;
  mod_resp_t mod_resp;

  // neighbor probe signals
  logic [1:0]         nb_sel;
  logic               nb_ok;
  logic [COORD_W-1:0] nb_r, nb_c, nb_wr, nb_wc;
  logic [2:0]         nb_cnt;
  logic [1:0]         pick_idx;
  logic [2:0]         pick_cnt;
  logic [COORD_W-1:0] half_cols, half_rows;
  logic [SIZE_W-1:0]  clamp_cols, clamp_rows;
  logic               rd_inside;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign half_cols = cur_cols[SIZE_W-1:1];
  assign half_rows = cur_rows[SIZE_W-1:1];

  // saturate a size register into 3..lim
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    if (v < SIZE_W'(3)) return SIZE_W'(3);
    if (v > lim) return lim;
    return v;
  endfunction

  assign clamp_cols = clamp_size(grid_cols, SIZE_W'(MAX_COLS));
  assign clamp_rows = clamp_size(grid_rows, SIZE_W'(MAX_ROWS));
  assign rd_inside  = ({1'b0, in_q.read_row} < cur_rows) && ({1'b0, in_q.read_col} < cur_cols);

  // pick the k-th open neighbor in left, right, up, down order
  always_comb begin
    pick_idx = 2'd0;
    pick_cnt = 3'd0;
    nb_cnt   = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (pick_cnt == {1'b0, mod_resp.rem[1:0]}) pick_idx = 2'(i);
        pick_cnt = pick_cnt + 3'd1;
        nb_cnt   = nb_cnt + 3'd1;
      end
    end
  end

  assign nb_sel = (state == S_MODC) ? pick_idx : nb_i;

  // neighbor coordinates, lattice bound and wall between
  always_comb begin
    nb_r  = cr;
    nb_c  = cc;
    nb_wr = cr;
    nb_wc = cc;
    nb_ok = 1'b0;
    case (nb_sel)
      2'd0: begin
        nb_ok = (cc > COORD_W'(1));
        nb_c  = cc - COORD_W'(2);
        nb_wc = cc - COORD_W'(1);
      end
      2'd1: begin
        nb_ok = ({1'b0, cc} + SIZE_W'(2)) <= (cur_cols - SIZE_W'(2));
        nb_c  = cc + COORD_W'(2);
        nb_wc = cc + COORD_W'(1);
      end
      2'd2: begin
        nb_ok = (cr > COORD_W'(1));
        nb_r  = cr - COORD_W'(2);
        nb_wr = cr - COORD_W'(1);
      end
      default: begin
        nb_ok = ({1'b0, cr} + SIZE_W'(2)) <= (cur_rows - SIZE_W'(2));
        nb_r  = cr + COORD_W'(2);
        nb_wr = cr + COORD_W'(1);
      end
    endcase
  end

  // drive the shared remainder unit
  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = in_q.rand_a;
    mod_req.divisor  = {3'b000, nb_cnt};
    unique case (state)
      S_PICK: mod_req.start = (nb_cnt != 3'd0);
      S_ENDC: begin
        mod_req.start   = 1'b1;
        mod_req.divisor = half_cols;
      end
      S_ENDR: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = in_q.rand_b;
        mod_req.divisor  = half_rows;
      end
      default: ;
    endcase
  end

  mdfs_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .resp (mod_resp)
  );

  // tile memory ports
  always_comb begin
    tile_we    = 1'b0;
    tile_waddr = clr_addr;
    tile_wdata = TK_WALL;
    tile_raddr = {er, ec};
    unique case (state)
      S_CLEAR: tile_we = 1'b1;
      S_SEED: begin
        tile_we    = 1'b1;
        tile_waddr = {COORD_W'(1), COORD_W'(1)};
        tile_wdata = TK_EMPTY;
      end
      S_WR1: begin
        tile_we    = 1'b1;
        tile_waddr = {tr, tc};
        tile_wdata = TK_EMPTY;
      end
      S_WR2: begin
        tile_we    = 1'b1;
        tile_waddr = {wr, wc};
        tile_wdata = TK_EMPTY;
      end
      S_ENDCK: begin
        tile_we    = (tile_rdata == TK_EMPTY);
        tile_waddr = {er, ec};
        tile_wdata = TK_END;
      end
      S_RD:   tile_raddr = {in_q.read_row, in_q.read_col};
      S_NBRD: tile_raddr = {nb_r, nb_c};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tile_we) tile_mem[tile_waddr] <= tile_wdata;
    tile_rdata <= tile_mem[tile_raddr];
  end

  // path stack ports
  assign stack_raddr = STACK_AW'(depth - DEPTH_W'(1));
  assign stack_we    = (state == S_SEED) ||
                       ((state == S_WR2) && (depth < DEPTH_W'(STACK_DEPTH)));
  assign stack_waddr = (state == S_SEED) ? '0 : depth[STACK_AW-1:0];

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= (state == S_SEED) ? {COORD_W'(1), COORD_W'(1)} : {tr, tc};
    end
    stack_rdata <= stack_mem[stack_raddr];
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (&clr_addr) state_next = seed_pend ? S_SEED : S_IDLE;
      S_SEED:  state_next = S_OUT;
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            OP_RESTART: state_next = S_CLEAR;
            OP_STEP: begin
              if (phase == PH_CARVE) state_next = S_TOP;
              else if (phase == PH_END) state_next = S_ENDC;
              else state_next = S_OUT;
            end
            OP_READ: state_next = S_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD:    state_next = rd_inside ? S_RDW : S_OUT;
      S_RDW:   state_next = S_OUT;
      S_TOP:   state_next = (depth == '0) ? S_ENDC : S_TOPW;
      S_TOPW:  state_next = S_NBRD;
      S_NBRD:  state_next = S_NBCK;
      S_NBCK:  state_next = (nb_i == 2'd3) ? S_PICK : S_NBRD;
      S_PICK:  state_next = (nb_cnt == 3'd0) ? S_TOP : S_MODC;
      S_MODC:  if (mod_resp.done) state_next = S_WR1;
      S_WR1:   state_next = S_WR2;
      S_WR2:   state_next = S_OUT;
      S_ENDC:  state_next = S_ENDCW;
      S_ENDCW: if (mod_resp.done) state_next = S_ENDR;
      S_ENDR:  state_next = S_ENDRW;
      S_ENDRW: if (mod_resp.done) state_next = S_ENDRD;
      S_ENDRD: state_next = S_ENDCK;
      S_ENDCK: state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      phase     <= PH_IDLE;
      seed_pend <= 1'b0;
      clr_addr  <= '0;
      depth     <= '0;
      vtotal    <= '0;
      grid_cols <= SIZE_W'(31);
      grid_rows <= SIZE_W'(31);
      cur_cols  <= SIZE_W'(31);
      cur_rows  <= SIZE_W'(31);
      cells     <= CELLS_W'(225);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_COLS) grid_cols <= cfg_data;
        if (cfg_index == CFG_ROWS) grid_rows <= cfg_data;
      end
      // load a new result word or drop the one just taken
      if ((state == S_OUT) && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + TILE_AW'(1);
        S_IDLE: begin
          if (in_valid && (in_data.opcode == OP_RESTART)) begin
            seed_pend <= 1'b1;
            cur_cols  <= clamp_cols;
            cur_rows  <= clamp_rows;
            cells     <= CELLS_W'((clamp_cols - SIZE_W'(1)) >> 1) *
                         CELLS_W'((clamp_rows - SIZE_W'(1)) >> 1);
            depth     <= '0;
            vtotal    <= '0;
            phase     <= PH_IDLE;
          end
        end
        S_SEED: begin
          seed_pend <= 1'b0;
          depth     <= DEPTH_W'(1);
          vtotal    <= CELLS_W'(1);
          phase     <= (cells <= CELLS_W'(1)) ? PH_END : PH_CARVE;
        end
        S_TOP:  if (depth == '0) phase <= PH_END;
        S_PICK: if (nb_cnt == 3'd0) depth <= depth - DEPTH_W'(1);
        S_WR2: begin
          if (depth < DEPTH_W'(STACK_DEPTH)) depth <= depth + DEPTH_W'(1);
          vtotal <= vtotal + CELLS_W'(1);
          if ((vtotal + CELLS_W'(1)) >= cells) phase <= PH_END;
        end
        S_ENDCK: if (tile_rdata == TK_EMPTY) phase <= PH_DONE;
        default: ;
      endcase
    end
  end

  // attach the completion flag to the result
  always_comb begin
    out_next           = res;
    out_next.maze_done = (phase == PH_END) || (phase == PH_DONE);
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) in_q <= in_data;
        res <= '{status: ST_FINISHED, default: '0};
      end
      S_SEED: begin
        res <= '{status: ST_RESTARTED, cell_row: COORD_W'(1), cell_col: COORD_W'(1),
                 tile_kind: TK_EMPTY, default: '0};
      end
      S_RD: begin
        res <= '{status: ST_READ, cell_row: in_q.read_row, cell_col: in_q.read_col,
                 tile_kind: TK_WALL, default: '0};
      end
      S_RDW: res.tile_kind <= tile_rdata;
      S_TOPW: begin
        cr   <= stack_rdata[TILE_AW-1:COORD_W];
        cc   <= stack_rdata[COORD_W-1:0];
        nb_i <= 2'd0;
        mask <= '0;
      end
      S_NBCK: begin
        mask[nb_i] <= nb_ok && (tile_rdata == TK_WALL);
        nb_i       <= nb_i + 2'd1;
      end
      S_MODC: begin
        tr <= nb_r;
        tc <= nb_c;
        wr <= nb_wr;
        wc <= nb_wc;
      end
      S_WR2: begin
        res <= '{status: ST_CARVED, cell_row: tr, cell_col: tc, wall_row: wr,
                 wall_col: wc, tile_kind: TK_EMPTY, default: '0};
      end
      S_ENDCW: if (mod_resp.done) ec <= half_cols + mod_resp.rem;
      S_ENDRW: if (mod_resp.done) er <= half_rows + mod_resp.rem;
      S_ENDCK: begin
        res <= '{status: (tile_rdata == TK_EMPTY) ? ST_END_OK : ST_END_REJ,
                 cell_row: er, cell_col: ec,
                 tile_kind: (tile_rdata == TK_EMPTY) ? TK_END : tile_rdata,
                 default: '0};
      end
      S_OUT: if (!out_valid || out_ready) out_data <= out_next;
      default: ;
    endcase
  end

  // checks
  `MDFS_ASSERT_NEXT(a_push, (state == S_WR2) && (depth < DEPTH_W'(STACK_DEPTH)), depth == $past(depth) + DEPTH_W'(1), "stack push lost")
  `MDFS_ASSERT_NOW(a_visits, phase != PH_IDLE, vtotal <= cells, "more cells visited than exist")
  `MDFS_ASSERT_NEXT(a_carve, (state == S_MODC) && mod_resp.done, state == S_WR1, "carve skipped after pick")

endmodule

// ===== verif/maze_dfs_checker.sv =====
// Scoreboard for the maze generator: tracks the grid, the path stack and the
// generation phase, and compares every result word with its prediction.
// Depends on mdfs_pkg.
module maze_dfs_checker import mdfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_word_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                pending,
  output int                mismatches
);

  typedef enum logic [1:0] {GEN_IDLE, GEN_CARVE, GEN_END, GEN_DONE} gen_state_e;

  logic [1:0]         tiles   [MAX_ROWS*MAX_COLS];
  bit                 seen    [MAX_ROWS*MAX_COLS];
  logic [COORD_W-1:0] trail_r [STACK_DEPTH];
  logic [COORD_W-1:0] trail_c [STACK_DEPTH];
  int                 trail_len;
  int                 carved_cells;
  gen_state_e         gen;
  int                 lat_cols, lat_rows;
  logic [SIZE_W-1:0]  reg_cols, reg_rows;
  out_word_t          expected_q[$];

  function automatic out_word_t make_word(logic [2:0] st, int cr, int cc, int wr, int wc,
                                          logic [1:0] kind);
    out_word_t w;
    w.status    = st;
    w.cell_row  = COORD_W'(cr);
    w.cell_col  = COORD_W'(cc);
    w.wall_row  = COORD_W'(wr);
    w.wall_col  = COORD_W'(wc);
    w.tile_kind = kind;
    w.maze_done = (gen == GEN_END || gen == GEN_DONE);
    return w;
  endfunction

  // propose an end tile in the lower right quadrant
  function automatic out_word_t try_end(logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb);
    int hc, hr, c, r, idx;
    hc = lat_cols / 2;
    hr = lat_rows / 2;
    c = hc + int'(ra) % hc;
    r = hr + int'(rb) % hr;
    idx = r * MAX_COLS + c;
    if (tiles[idx] == TK_EMPTY) begin
      tiles[idx] = TK_END;
      gen = GEN_DONE;
      return make_word(ST_END_OK, r, c, 0, 0, TK_END);
    end
    return make_word(ST_END_REJ, r, c, 0, 0, tiles[idx]);
  endfunction

  // pop until the top has an unvisited neighbour, then carve toward it
  function automatic out_word_t carve(logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb);
    int r, c, n, k, tr, tc, wr, wc;
    int nr[4], nc[4];
    while (trail_len > 0) begin
      r = trail_r[trail_len-1];
      c = trail_c[trail_len-1];
      n = 0;
      if (c > 1 && !seen[r*MAX_COLS + c-2]) begin
        nr[n] = r; nc[n] = c - 2; n++;
      end
      if (c + 2 <= lat_cols - 2 && !seen[r*MAX_COLS + c+2]) begin
        nr[n] = r; nc[n] = c + 2; n++;
      end
      if (r > 1 && !seen[(r-2)*MAX_COLS + c]) begin
        nr[n] = r - 2; nc[n] = c; n++;
      end
      if (r + 2 <= lat_rows - 2 && !seen[(r+2)*MAX_COLS + c]) begin
        nr[n] = r + 2; nc[n] = c; n++;
      end
      if (n > 0) begin
        k = int'(ra) % n;
        tr = nr[k];
        tc = nc[k];
        wr = (r + tr) / 2;
        wc = (c + tc) / 2;
        seen[tr*MAX_COLS + tc] = 1;
        tiles[tr*MAX_COLS + tc] = TK_EMPTY;
        tiles[wr*MAX_COLS + wc] = TK_EMPTY;
        carved_cells++;
        // drop the push when the stack is full
        if (trail_len < STACK_DEPTH) begin
          trail_r[trail_len] = COORD_W'(tr);
          trail_c[trail_len] = COORD_W'(tc);
          trail_len++;
        end
        if (carved_cells >= ((lat_cols-1)/2) * ((lat_rows-1)/2)) gen = GEN_END;
        return make_word(ST_CARVED, tr, tc, wr, wc, TK_EMPTY);
      end
      trail_len--;
    end
    gen = GEN_END;
    return try_end(ra, rb);
  endfunction

  function automatic bit predict(in_word_t w, output out_word_t res);
    int r, c;
    case (w.opcode)
      OP_RESTART: begin
        lat_cols = reg_cols < 3 ? 3 : (reg_cols > MAX_COLS ? MAX_COLS : reg_cols);
        lat_rows = reg_rows < 3 ? 3 : (reg_rows > MAX_ROWS ? MAX_ROWS : reg_rows);
        for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) begin
          tiles[i] = TK_WALL;
          seen[i] = 0;
        end
        tiles[MAX_COLS + 1] = TK_EMPTY;
        seen[MAX_COLS + 1] = 1;
        trail_r[0] = 1;
        trail_c[0] = 1;
        trail_len = 1;
        carved_cells = 1;
        gen = (((lat_cols-1)/2) * ((lat_rows-1)/2) <= 1) ? GEN_END : GEN_CARVE;
        res = make_word(ST_RESTARTED, 1, 1, 0, 0, TK_EMPTY);
      end
      OP_STEP: begin
        if (gen == GEN_CARVE) res = carve(w.rand_a, w.rand_b);
        else if (gen == GEN_END) res = try_end(w.rand_a, w.rand_b);
        else res = make_word(ST_FINISHED, 0, 0, 0, 0, TK_WALL);
      end
      OP_READ: begin
        r = w.read_row;
        c = w.read_col;
        res = make_word(ST_READ, r, c, 0, 0,
                        (r < lat_rows && c < lat_cols) ? tiles[r*MAX_COLS + c] : TK_WALL);
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare the oldest prediction, then track config and new input words
  always @(posedge clk) begin
    out_word_t want, res;
    if (rst) begin
      for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) begin
        tiles[i] = TK_WALL;
        seen[i] = 0;
      end
      trail_len = 0;
      carved_cells = 0;
      gen = GEN_IDLE;
      reg_cols = 31;
      reg_rows = 31;
      lat_cols = 31;
      lat_rows = 31;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("cell_row", want.cell_row, out_data.cell_row);
          check_field("cell_col", want.cell_col, out_data.cell_col);
          check_field("wall_row", want.wall_row, out_data.wall_row);
          check_field("wall_col", want.wall_col, out_data.wall_col);
          check_field("tile_kind", want.tile_kind, out_data.tile_kind);
          check_field("maze_done", want.maze_done, out_data.maze_done);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLS) reg_cols = cfg_data;
        else reg_rows = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (predict(in_data, res)) expected_q = {expected_q, res};
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/maze_dfs_backtracker_tb.sv =====
// Testbench top for the maze generator: drives directed and random words,
// size changes and back-pressure; the verdict comes from maze_dfs_checker.
// Depends on mdfs_pkg, maze_dfs_checker and the maze_dfs_backtracker RTL.
module maze_dfs_backtracker_tb import mdfs_pkg::*;;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int WORD_TARGET = 1400;
  localparam int QUIET_AFTER = 1250;
  localparam logic [1:0] OP_NOP = 2'd3;

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_ready;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 0;
  out_word_t         out_data;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic              cfg_index = CFG_COLS;
  logic [SIZE_W-1:0] cfg_data = '0;
  int                pending;
  int                mismatches;
  int                words_sent = 0;
  int                cycles = 0;
  int                hold = 0;
  bit                quiet;

  assign quiet = words_sent >= QUIET_AFTER;

  maze_dfs_backtracker u_top (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  maze_dfs_checker u_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .mismatches
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stall the result side in bursts
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (quiet || rst) begin
      out_ready <= 1;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 0;
      hold <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1;
    end
  end

  // give up on a hung block
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, int ra, int rb, int rr, int rc);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{opcode: op, rand_a: RAND_W'(ra), rand_b: RAND_W'(rb),
                 read_row: COORD_W'(rr), read_col: COORD_W'(rc)};
    do @(posedge clk); while (!in_ready);
    if (op != OP_NOP) words_sent++;
  endtask

  task automatic step_word();
    send(OP_STEP, $urandom_range(0, 32767), $urandom_range(0, 32767), 0, 0);
  endtask

  // hold off until the block is idle, with room for a trailing no-op
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_size(int cols, int rows);
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_COLS, SIZE_W'(cols));
      write_reg(CFG_ROWS, SIZE_W'(rows));
    end else begin
      write_reg(CFG_ROWS, SIZE_W'(rows));
      write_reg(CFG_COLS, SIZE_W'(cols));
    end
  endtask

  initial begin
    int cols, rows, lc, lr, steps, target, roll, pick;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: idle block, smallest grids, random word extremes
    send(OP_READ, 0, 0, 0, 0);
    send(OP_STEP, 0, 0, 0, 0);
    send(OP_NOP, 15'h7fff, 15'h7fff, 63, 63);
    set_size(3, 3);
    send(OP_RESTART, 0, 0, 0, 0);
    send(OP_STEP, 15'h7fff, 15'h7fff, 0, 0);
    send(OP_STEP, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 1, 1);
    send(OP_READ, 0, 0, 63, 63);
    set_size(4, 4);
    send(OP_RESTART, 0, 0, 0, 0);
    send(OP_STEP, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 2, 2);
    set_size(5, 5);
    send(OP_RESTART, 0, 0, 0, 0);
    send(OP_STEP, 0, 0, 0, 0);
    send(OP_STEP, 15'h7fff, 0, 0, 0);
    send(OP_STEP, 15'h7fff, 15'h7fff, 0, 0);
    send(OP_STEP, 0, 15'h7fff, 0, 0);
    send(OP_STEP, 15'h5555, 15'h2aaa, 0, 0);
    send(OP_READ, 0, 0, 4, 4);
    send(OP_READ, 0, 0, 1, 2);

    // random phases: one size, a restart, then steps mixed with reads, no-ops and restarts
    pick = 0;
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        case (pick % 5)
          0: begin cols = 64;  rows = 64; end
          1: begin cols = 127; rows = 5;  end
          2: begin cols = 0;   rows = 64; end
          3: begin cols = 3;   rows = 40; end
          default: begin cols = 31; rows = 31; end
        endcase
        pick++;
      end else begin
        cols = $urandom_range(3, 17);
        rows = $urandom_range(3, 17);
      end
      set_size(cols, rows);
      lc = cols < 3 ? 3 : (cols > MAX_COLS ? MAX_COLS : cols);
      lr = rows < 3 ? 3 : (rows > MAX_ROWS ? MAX_ROWS : rows);
      target = ((lc - 1) / 2) * ((lr - 1) / 2) + $urandom_range(2, 8);
      if (target > 200) target = 200;
      send(OP_RESTART, $urandom_range(0, 32767), $urandom_range(0, 32767), 0, 0);
      steps = 0;
      while (steps < target && words_sent < WORD_TARGET) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          if ($urandom_range(0, 1))
            send(OP_READ, $urandom_range(0, 32767), $urandom_range(0, 32767),
                 $urandom_range(0, 63), $urandom_range(0, 63));
          else
            send(OP_READ, $urandom_range(0, 32767), $urandom_range(0, 32767),
                 $urandom_range(0, lr), $urandom_range(0, lc));
        end else if (roll < 28) begin
          send(OP_NOP, $urandom_range(0, 32767), $urandom_range(0, 32767),
               $urandom_range(0, 63), $urandom_range(0, 63));
        end else if (roll == 28) begin
          send(OP_RESTART, $urandom_range(0, 32767), $urandom_range(0, 32767), 0, 0);
        end else begin
          step_word();
          steps++;
        end
      end
    end

    // drain and give the verdict
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
